>>> rtl/core/bpr_pkg.sv
// Shared types and constants for the binomial Pascal-row core.
// Used by bpr_ctrl, bpr_datapath and the top level; no dependencies.
package bpr_pkg;

  localparam int unsigned MAX_N     = 1023;
  localparam int unsigned MAX_R     = 1023;
  localparam int unsigned CNT_W     = 10;
  localparam int unsigned MOD_W     = 31;
  localparam int unsigned ROW_DEPTH = MAX_R + 1;
  localparam int unsigned ADDR_W    = $clog2(ROW_DEPTH);

  localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_ONE,
    RES_MEM
  } res_sel_e;

  typedef struct packed {
    logic     load;
    logic     init_wr;
    logic     row_begin;
    logic     row_read;
    logic     row_active;
    logic     next_row;
    logic     fetch;
    logic     res_load;
    res_sel_e res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic trivial_zero;
    logic trivial_one;
    logic init_last;
    logic j_one;
    logic row_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/core/bpr_datapath.sv
// Datapath: modulus register, row store, counters, modular adder, output register.
// Depends on bpr_pkg; driven by bpr_ctrl through dp_cmd_t.
module bpr_datapath import bpr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               modulus_we_i,
  input  logic [MOD_W-1:0]   modulus_i,
  input  logic [CNT_W-1:0]   total_count_i,
  input  logic [CNT_W-1:0]   chosen_count_i,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [MOD_W-1:0]   coefficient_o
);

  logic [MOD_W-1:0]  mod_q;
  logic [CNT_W-1:0]  n_q, r_q, i_q;
  logic [ADDR_W-1:0] j_q, j_d, wa_q, wa_d;
  logic [MOD_W-1:0]  rd_q, prev_q;
  logic              rd_vld_q, have_prev_q;
  logic [MOD_W-1:0]  coef_q;
  logic              out_valid_q;

  logic [MOD_W-1:0]  row_mem [ROW_DEPTH];

  logic [CNT_W-1:0]  top;
  logic              re, we;
  logic [ADDR_W-1:0] ra, wa;
  logic [MOD_W-1:0]  wd;
  logic [MOD_W:0]    sum;
  logic [MOD_W-1:0]  sum_mod;
  logic              consume;

  assign top = (i_q < r_q) ? i_q : r_q;

  // Modular add of the two old entries; both are below the modulus.
  assign sum     = {1'b0, prev_q} + {1'b0, rd_q};
  assign sum_mod = (sum >= {1'b0, mod_q}) ? MOD_W'(sum - {1'b0, mod_q}) : sum[MOD_W-1:0];

  assign consume = cmd_i.row_active && rd_vld_q;

  always_comb begin
    re   = 1'b0;
    ra   = j_q;
    we   = 1'b0;
    wa   = wa_q;
    wd   = sum_mod;
    j_d  = j_q;
    wa_d = wa_q;
    if (cmd_i.load) begin
      j_d = '0;
    end
    if (cmd_i.init_wr) begin
      we  = 1'b1;
      wa  = j_q;
      wd  = (j_q == '0) ? MOD_W'(1) : '0;
      j_d = j_q + ADDR_W'(1);
    end
    if (cmd_i.row_begin) begin
      re   = 1'b1;
      ra   = top[ADDR_W-1:0];
      j_d  = top[ADDR_W-1:0];
      wa_d = top[ADDR_W-1:0];
    end
    if (cmd_i.row_read) begin
      re  = 1'b1;
      ra  = j_q - ADDR_W'(1);
      j_d = j_q - ADDR_W'(1);
    end
    if (consume && have_prev_q) begin
      we   = 1'b1;
      wa   = wa_q;
      wd   = sum_mod;
      wa_d = wa_q - ADDR_W'(1);
    end
    if (cmd_i.fetch) begin
      re = 1'b1;
      ra = r_q[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      row_mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= row_mem[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q       <= MODULUS_RESET;
      rd_vld_q    <= 1'b0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (modulus_we_i) begin
        mod_q <= modulus_i;
      end
      rd_vld_q <= re;
      if (cmd_i.row_begin) begin
        have_prev_q <= 1'b0;
      end else if (consume) begin
        have_prev_q <= 1'b1;
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    j_q  <= j_d;
    wa_q <= wa_d;
    if (cmd_i.load) begin
      n_q <= total_count_i;
      r_q <= chosen_count_i;
      i_q <= CNT_W'(1);
    end else if (cmd_i.next_row) begin
      i_q <= i_q + CNT_W'(1);
    end
    if (consume) begin
      prev_q <= rd_q;
    end
    if (cmd_i.res_load) begin
      unique case (cmd_i.res_sel)
        RES_ZERO: coef_q <= '0;
        RES_ONE:  coef_q <= MOD_W'(1);
        RES_MEM:  coef_q <= rd_q;
        default:  coef_q <= '0;
      endcase
    end
  end

  assign status_o.trivial_zero = (mod_q < MOD_W'(2)) || (r_q > n_q);
  assign status_o.trivial_one  = (r_q == '0);
  assign status_o.init_last    = (j_q == r_q[ADDR_W-1:0]);
  assign status_o.j_one        = (j_q == ADDR_W'(1));
  assign status_o.row_last     = (i_q == n_q);
  assign status_o.out_free     = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign coefficient_o = coef_q;

endmodule

>>> rtl/core/bpr_ctrl.sv
// Sequencer: setup sweep, row-by-row updates, final fetch, result handoff.
// Depends on bpr_pkg; commands bpr_datapath.
module bpr_ctrl import bpr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_INIT,
    ST_ROW_BEGIN,
    ST_ROW_READ,
    ST_DRAIN,
    ST_FETCH,
    ST_PUT
  } state_e;

  state_e   state_q, state_d;
  res_sel_e sel_q, sel_d;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.res_sel = sel_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (status_i.trivial_zero) begin
          sel_d   = RES_ZERO;
          state_d = ST_PUT;
        end else if (status_i.trivial_one) begin
          sel_d   = RES_ONE;
          state_d = ST_PUT;
        end else begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (status_i.init_last) begin
          state_d = ST_ROW_BEGIN;
        end
      end
      ST_ROW_BEGIN: begin
        cmd_o.row_begin = 1'b1;
        state_d         = ST_ROW_READ;
      end
      ST_ROW_READ: begin
        cmd_o.row_read   = 1'b1;
        cmd_o.row_active = 1'b1;
        if (status_i.j_one) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last entry of the row lands here; advance to the next row or finish
        cmd_o.row_active = 1'b1;
        if (status_i.row_last) begin
          state_d = ST_FETCH;
        end else begin
          cmd_o.next_row = 1'b1;
          state_d        = ST_ROW_BEGIN;
        end
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        sel_d       = RES_MEM;
        state_d     = ST_PUT;
      end
      ST_PUT: begin
        // hold until the output register can take the word
        if (status_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= RES_ZERO;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

>>> rtl/core/binomial_pascal_row_modular_core.sv
// Channel   Direction  Handshake               Payload
// request   in         in_valid_i/in_stall_o   total_count_i, chosen_count_i
// result    out        out_valid_o/out_stall_i coefficient_o
// config    in         modulus_we_i            modulus_i
//
// A request first sweeps row store entries 0..r, then rebuilds each row i = 1..n
// in place over entries min(i, r) down to 1. The row store has a single read port: one entry
// is read and one written per cycle while each row is rebuilt.
// Trivial requests (r > n, r = 0, modulus below 2) skip the sweeps and go straight to the result.
// Reset is asynchronous, active low; the row store needs no clearing pass.
// A result word waiting on out_stall_i does not block the next request; a second
// finished word holds in the sequencer, with the input stalled, until it drains.
module binomial_pascal_row_modular_core import bpr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             modulus_we_i,
  input  logic [MOD_W-1:0] modulus_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CNT_W-1:0] total_count_i,
  input  logic [CNT_W-1:0] chosen_count_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [MOD_W-1:0] coefficient_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  bpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bpr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .modulus_we_i   (modulus_we_i),
    .modulus_i      (modulus_i),
    .total_count_i  (total_count_i),
    .chosen_count_i (chosen_count_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .coefficient_o  (coefficient_o)
  );

endmodule

>>> rtl/core/bpr_checker.sv
// Port-level checks for binomial_pascal_row_modular_core, bound to the top.
// Depends on bpr_pkg for field widths.
module bpr_checker import bpr_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [MOD_W-1:0] coefficient_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(coefficient_o))
    else $error("stalled result word changed");

  // an accepted request makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while not going busy");

  // a new result only appears out of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word without a request in flight");

  // a residue is always below the modulus, so never all ones
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> coefficient_o != {MOD_W{1'b1}})
    else $error("result word out of range");

endmodule

bind binomial_pascal_row_modular_core bpr_checker u_bpr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .coefficient_o (coefficient_o)
);

>>> dv/binomial_pascal_row_modular_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for binomial_pascal_row_modular_core: C(n,r) mod a
// programmable modulus, checked word by word against a Pascal-row predictor.
// Depends on bpr_pkg and the core RTL only.
module binomial_pascal_row_modular_core_tb;
  import bpr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned HOLD_CYCLES = 1500;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned DIR_ROWS    = 23;

  typedef struct packed {
    bit               set_mod;
    logic [MOD_W-1:0] mod_val;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] r;
    bit               known;
    logic [MOD_W-1:0] coeff;
  } dir_row_t;

  typedef struct {
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] r;
    logic [MOD_W-1:0] coeff;
  } coeff_entry_t;

  // set_mod, modulus, n, r, known, coefficient
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{0, 0, 0, 0, 1, 1},
    '{0, 0, 1, 0, 1, 1},
    '{0, 0, 1, 1, 1, 1},
    '{0, 0, 0, 1, 1, 0},
    '{0, 0, 1023, 0, 1, 1},
    '{0, 0, 0, 1023, 1, 0},
    '{0, 0, 1022, 1023, 1, 0},
    '{0, 0, 1023, 1, 1, 1023},
    '{0, 0, 5, 5, 1, 1},
    '{0, 0, 6, 3, 1, 20},
    '{0, 0, 30, 15, 0, 0},
    '{0, 0, 40, 20, 0, 0},
    '{0, 0, 1023, 3, 0, 0},
    '{0, 0, 512, 2, 0, 0},
    '{0, 0, 21, 682, 1, 0},
    '{1, 2, 4, 2, 1, 0},
    '{0, 0, 7, 3, 1, 1},
    '{1, 1, 10, 5, 1, 0},
    '{0, 0, 0, 0, 1, 0},
    '{1, 0, 3, 1, 1, 0},
    '{1, 31'h7FFF_FFFF, 1023, 2, 0, 0},
    '{0, 0, 60, 30, 0, 0},
    '{1, MODULUS_RESET, 20, 10, 1, 184756}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             modulus_we_i;
  logic [MOD_W-1:0] modulus_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [CNT_W-1:0] total_count_i;
  logic [CNT_W-1:0] chosen_count_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [MOD_W-1:0] coefficient_o;

  logic [MOD_W-1:0] cfg_modulus = MODULUS_RESET;
  coeff_entry_t     coeff_pending [$];
  int               fail_count   = 0;
  int unsigned      cycle_count  = 0;
  bit               hold_off_req = 1'b0;
  bit               no_idle      = 1'b0;

  binomial_pascal_row_modular_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .modulus_we_i   (modulus_we_i),
    .modulus_i      (modulus_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .total_count_i  (total_count_i),
    .chosen_count_i (chosen_count_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .coefficient_o  (coefficient_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Build rows 0..n of Pascal's triangle in one store, walking j downward.
  function automatic logic [MOD_W-1:0] pascal_coeff(input int unsigned n,
                                                     input int unsigned r,
                                                     input logic [MOD_W-1:0] m);
    logic [MOD_W-1:0] row [ROW_DEPTH];
    logic [MOD_W:0]   sum;
    int               top;
    if (m < 2 || r > n) return '0;
    row[0] = MOD_W'(1);
    for (int j = 1; j <= int'(r); j++) row[j] = '0;
    for (int i = 1; i <= int'(n); i++) begin
      top = (i < int'(r)) ? i : int'(r);
      for (int j = top; j >= 1; j--) begin
        sum = {1'b0, row[j]} + {1'b0, row[j-1]};
        if (sum >= {1'b0, m}) sum = sum - {1'b0, m};
        row[j] = sum[MOD_W-1:0];
      end
    end
    return row[r];
  endfunction

  // Offer one request word; valid stays high so a following word goes out back to back.
  task automatic send_request(input logic [CNT_W-1:0] n, input logic [CNT_W-1:0] r,
                              input bit known, input logic [MOD_W-1:0] known_coeff);
    coeff_entry_t entry;
    in_valid_i     <= 1'b1;
    total_count_i  <= n;
    chosen_count_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    entry.n     = n;
    entry.r     = r;
    entry.coeff = known ? known_coeff : pascal_coeff(n, r, cfg_modulus);
    coeff_pending.push_back(entry);
  endtask

  task automatic sender_gap();
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // Pause the sender until every coefficient has come back, then let the core settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (coeff_pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_modulus(input logic [MOD_W-1:0] value);
    modulus_we_i <= 1'b1;
    modulus_i    <= value;
    @(posedge clk_i);
    modulus_we_i <= 1'b0;
    cfg_modulus = value;
  endtask

  // Mostly small rows; a few tall rows with narrow r, and r > n noise.
  task automatic send_random(input int count);
    int unsigned n;
    int unsigned r;
    int unsigned mode;
    for (int k = 0; k < count; k++) begin
      mode = $urandom_range(0, 19);
      if (mode < 2) begin
        n = $urandom_range(0, 1023);
        r = $urandom_range(0, 6);
      end else if (mode < 4) begin
        n = $urandom_range(0, 1022);
        r = $urandom_range(n + 1, 1023);
      end else if (mode == 4) begin
        n = $urandom_range(0, 40);
        r = $urandom_range(0, 1) ? n : 0;
      end else begin
        n = $urandom_range(0, 40);
        r = $urandom_range(0, n + 2);
      end
      send_request(n[CNT_W-1:0], r[CNT_W-1:0], 1'b0, '0);
      sender_gap();
    end
  endtask

  // Receiver: random stall bursts, calm stretches, and one long hold-off on request.
  initial begin : result_stall
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_off_req = 1'b0;
      end else if (!no_idle) begin
        if ($urandom_range(0, 7) == 0) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(1, 19)) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end else if ($urandom_range(0, 63) == 0) begin
          repeat ($urandom_range(20, 150)) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    coeff_entry_t want;
    if (rst_ni === 1'b1 && out_valid_o && !out_stall_i) begin
      if (coeff_pending.size() == 0) begin
        $error("coefficient: no word expected, actual %0d", coefficient_o);
        fail_count++;
      end else begin
        want = coeff_pending.pop_front();
        if (coefficient_o !== want.coeff) begin
          $error("coefficient: expected %0d, actual %0d (n=%0d r=%0d)",
                 want.coeff, coefficient_o, want.n, want.r);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    rst_ni         <= 1'b0;
    modulus_we_i   <= 1'b0;
    modulus_i      <= '0;
    in_valid_i     <= 1'b0;
    total_count_i  <= '0;
    chosen_count_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < DIR_ROWS; k++) begin
      if (DIRECTED[k].set_mod) begin
        drain_results();
        set_modulus(DIRECTED[k].mod_val);
      end
      send_request(DIRECTED[k].n, DIRECTED[k].r, DIRECTED[k].known, DIRECTED[k].coeff);
      sender_gap();
    end

    drain_results();
    set_modulus(31'd2);
    send_random(15);

    // Hold the result side while requests keep coming, so the core backs up.
    drain_results();
    set_modulus(31'h7FFF_FFFF);
    hold_off_req = 1'b1;
    send_random(20);

    drain_results();
    set_modulus(31'd1);
    send_random(5);
    drain_results();
    set_modulus(31'd0);
    send_random(4);

    drain_results();
    set_modulus(MOD_W'($urandom_range(3, 97)));
    send_random(20);

    drain_results();
    no_idle = 1'b1;
    set_modulus(MOD_W'($urandom_range(2, 32'h7FFF_FFFF)));
    send_random(25);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
